/* rtl/hpd_pkg.sv */
package hpd_pkg;

	// default sizes
	localparam int TABLE_DEPTH_DEF  = 256;
	localparam int MAX_CODE_LEN_DEF = 16;

	// field widths
	localparam int CMD_W          = 2;
	localparam int ENTRY_INDEX_W  = 8;
	localparam int ENTRY_SYMBOL_W = 8;
	localparam int ENTRY_LEN_W    = 5;
	localparam int ENTRY_CODE_W   = 16;
	localparam int BYTE_W         = 8;
	localparam int VALID_BITS_W   = 4;

	// bits are taken from the top of the data byte down
	localparam int BYTE_TOP  = 7;
	localparam int BYTE_BITS = BYTE_TOP + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_DATA  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_SCAN,
		ST_PLACE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [ENTRY_SYMBOL_W-1:0] symbol;
		logic [ENTRY_LEN_W-1:0]    length;
		logic [ENTRY_CODE_W-1:0]   code;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic do_clear;     // wipe table valid bits and partial code
		logic do_write;     // write one table entry
		logic do_load;      // load data byte and bit count
		logic shift_bit;    // append next stream bit, restart scan
		logic scan_rd;      // read next table entry
		logic take_result;  // latch scan outcome, clear partial code
		logic place_hold;   // move latched result into hold slot
		logic push_mid;     // hold slot -> output, not last
		logic push_last;    // hold slot -> output, last of byte
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;
		logic scan_end;
		logic at_max;
		logic bits_left;
		logic hold_valid;
		logic out_free;
	} dp_stat_t;

endpackage

/* rtl/hpd_ctrl.sv */
module hpd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hpd_pkg::CMD_W-1:0]        command,
	input  logic [hpd_pkg::VALID_BITS_W-1:0] valid_bits,
	input  hpd_pkg::dp_stat_t             stat,
	output hpd_pkg::ctrl_cmd_t            cmd
);

	hpd_pkg::state_t state_q, state_nxt;
	logic            accept;
	logic            result_now;

	assign accept     = in_valid && (state_q == hpd_pkg::ST_IDLE);
	assign result_now = stat.hit || (stat.scan_end && stat.at_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			hpd_pkg::ST_IDLE: begin
				if (accept && (command == hpd_pkg::CMD_DATA) && (valid_bits != '0)) begin
					state_nxt = hpd_pkg::ST_BIT;
				end
			end
			hpd_pkg::ST_BIT: begin
				state_nxt = hpd_pkg::ST_SCAN;
			end
			hpd_pkg::ST_SCAN: begin
				priority if (result_now) begin
					state_nxt = hpd_pkg::ST_PLACE;
				end else if (stat.scan_end) begin
					state_nxt = stat.bits_left ? hpd_pkg::ST_BIT : hpd_pkg::ST_FLUSH;
				end
			end
			hpd_pkg::ST_PLACE: begin
				if (!stat.hold_valid || stat.out_free) begin
					state_nxt = stat.bits_left ? hpd_pkg::ST_BIT : hpd_pkg::ST_FLUSH;
				end
			end
			hpd_pkg::ST_FLUSH: begin
				if (!stat.hold_valid || stat.out_free) begin
					state_nxt = hpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = hpd_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = (state_q != hpd_pkg::ST_IDLE);
		unique case (state_q)
			hpd_pkg::ST_IDLE: begin
				cmd.do_clear = accept && (command == hpd_pkg::CMD_CLEAR);
				cmd.do_write = accept && (command == hpd_pkg::CMD_WRITE);
				cmd.do_load  = accept && (command == hpd_pkg::CMD_DATA);
			end
			hpd_pkg::ST_BIT: begin
				cmd.shift_bit = 1'b1;
			end
			hpd_pkg::ST_SCAN: begin
				cmd.scan_rd     = !result_now && !stat.scan_end;
				cmd.take_result = result_now;
			end
			hpd_pkg::ST_PLACE: begin
				cmd.place_hold = !stat.hold_valid || stat.out_free;
				cmd.push_mid   = stat.hold_valid && stat.out_free;
			end
			hpd_pkg::ST_FLUSH: begin
				cmd.push_last = stat.hold_valid && stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/hpd_datapath.sv */
module hpd_datapath #(
	parameter int TABLE_DEPTH  = hpd_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_CODE_LEN = hpd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hpd_pkg::ctrl_cmd_t              cmd,
	output hpd_pkg::dp_stat_t               stat,
	input  logic [hpd_pkg::ENTRY_INDEX_W-1:0]  entry_index,
	input  logic [hpd_pkg::ENTRY_SYMBOL_W-1:0] entry_symbol,
	input  logic [hpd_pkg::ENTRY_LEN_W-1:0]    entry_length,
	input  logic [hpd_pkg::ENTRY_CODE_W-1:0]   entry_code,
	input  logic [hpd_pkg::BYTE_W-1:0]         data_byte,
	input  logic [hpd_pkg::VALID_BITS_W-1:0]   valid_bits,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [hpd_pkg::ENTRY_SYMBOL_W-1:0] symbol,
	output logic                            status,
	output logic                            last_of_item
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int SCNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int PL_W   = $clog2(MAX_CODE_LEN + 1);
	localparam int LEN_W  = (PL_W > hpd_pkg::ENTRY_LEN_W) ? PL_W : hpd_pkg::ENTRY_LEN_W;
	localparam int CODE_W = (MAX_CODE_LEN > hpd_pkg::ENTRY_CODE_W) ?
	                        MAX_CODE_LEN : hpd_pkg::ENTRY_CODE_W;
	localparam int SYM_W  = hpd_pkg::ENTRY_SYMBOL_W;

	// code table
	hpd_pkg::entry_t         mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [IDX_W-1:0]        wr_addr;
	logic                    wr_en;

	// scan
	logic [SCNT_W-1:0]       scan_cnt_q;
	logic [IDX_W-1:0]        rd_addr;
	logic                    rd_issue;
	hpd_pkg::entry_t         ent_s1;
	logic                    vld_s1;
	logic                    live_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    match;

	// partial code and byte
	logic [MAX_CODE_LEN-1:0] pcode_q;
	logic [PL_W-1:0]         plen_q;
	logic [hpd_pkg::BYTE_W-1:0]       byte_q;
	logic [hpd_pkg::VALID_BITS_W-1:0] bits_left_q;
	logic [hpd_pkg::VALID_BITS_W-1:0] nbits;

	// result staging
	logic [SYM_W-1:0]        cand_sym_q;
	logic                    cand_err_q;
	logic                    hold_valid_q;
	logic [SYM_W-1:0]        hold_sym_q;
	logic                    hold_err_q;
	logic                    out_valid_q;
	logic [SYM_W-1:0]        symbol_q;
	logic                    status_q;
	logic                    last_q;
	logic                    out_free;
	logic                    push;

	assign wr_addr  = entry_index[IDX_W-1:0];
	assign wr_en    = cmd.do_write && (32'(entry_index) < 32'(TABLE_DEPTH));
	assign rd_addr  = scan_cnt_q[IDX_W-1:0];
	assign rd_issue = cmd.scan_rd && (scan_cnt_q < SCNT_W'(TABLE_DEPTH));
	assign nbits    = (valid_bits > hpd_pkg::VALID_BITS_W'(hpd_pkg::BYTE_BITS)) ?
	                  hpd_pkg::VALID_BITS_W'(hpd_pkg::BYTE_BITS) : valid_bits;

	assign match = vld_s1
	            && (LEN_W'(ent_s1.length) == LEN_W'(plen_q))
	            && (CODE_W'(ent_s1.code) == CODE_W'(pcode_q));

	assign out_free = !out_valid_q || !out_stall;
	assign push     = cmd.push_mid || cmd.push_last;

	assign stat.hit        = live_s1 && match;
	assign stat.scan_end   = live_s1 && !match && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));
	assign stat.at_max     = (plen_q >= PL_W'(MAX_CODE_LEN));
	assign stat.bits_left  = (bits_left_q != '0);
	assign stat.hold_valid = hold_valid_q;
	assign stat.out_free   = out_free;

	assign out_valid    = out_valid_q;
	assign symbol       = symbol_q;
	assign status       = status_q;
	assign last_of_item = last_q;

	// table storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{symbol: entry_symbol, length: entry_length, code: entry_code};
		end
		ent_s1 <= mem[rd_addr];
		idx_s1 <= rd_addr;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			vld_s1       <= 1'b0;
			live_s1      <= 1'b0;
			scan_cnt_q   <= '0;
			pcode_q      <= '0;
			plen_q       <= '0;
			bits_left_q  <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.do_clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end

			vld_s1  <= valid_q[rd_addr];
			live_s1 <= rd_issue;

			if (cmd.shift_bit) begin
				scan_cnt_q <= '0;
			end else if (rd_issue) begin
				scan_cnt_q <= scan_cnt_q + SCNT_W'(1);
			end

			if (cmd.do_clear || cmd.take_result) begin
				pcode_q <= '0;
				plen_q  <= '0;
			end else if (cmd.shift_bit) begin
				pcode_q <= {pcode_q[MAX_CODE_LEN-2:0], byte_q[hpd_pkg::BYTE_TOP]};
				plen_q  <= plen_q + PL_W'(1);
			end

			if (cmd.do_load) begin
				bits_left_q <= nbits;
			end else if (cmd.shift_bit) begin
				bits_left_q <= bits_left_q - hpd_pkg::VALID_BITS_W'(1);
			end

			if (cmd.place_hold) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.push_last) begin
				hold_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.do_load) begin
			byte_q <= data_byte;
		end else if (cmd.shift_bit) begin
			byte_q <= {byte_q[hpd_pkg::BYTE_W-2:0], 1'b0};
		end

		if (cmd.take_result) begin
			cand_sym_q <= match ? ent_s1.symbol : '0;
			cand_err_q <= !match;
		end

		if (cmd.place_hold) begin
			hold_sym_q <= cand_sym_q;
			hold_err_q <= cand_err_q;
		end

		if (push) begin
			symbol_q <= hold_sym_q;
			status_q <= hold_err_q;
			last_q   <= cmd.push_last;
		end
	end

endmodule

/* rtl/huffman_prefix_decoder.sv */
// Channel  Handshake            Beat contents
// -------  -------------------  -------------------------------------------------
// in       in_valid / in_stall  command, entry_index, entry_symbol, entry_length,
//                               entry_code, data_byte, valid_bits
// out      out_valid/out_stall  symbol, status, last_of_item
//
// Clear and table-write beats leave the decoder idle, ready for the next beat. A
// data beat with n stream bits holds in_stall high until it is done: every bit
// needs a linear scan of the table memory, one entry per cycle through its single
// read port, stopping at the first hit.
// Reset (arst_n low) marks all table entries invalid and clears the partial code.
// A stalled output holds its beat; the decoder waits for room before moving on.

module huffman_prefix_decoder #(
	parameter int TABLE_DEPTH  = hpd_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_CODE_LEN = hpd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [hpd_pkg::CMD_W-1:0]          command,
	input  logic [hpd_pkg::ENTRY_INDEX_W-1:0]  entry_index,
	input  logic [hpd_pkg::ENTRY_SYMBOL_W-1:0] entry_symbol,
	input  logic [hpd_pkg::ENTRY_LEN_W-1:0]    entry_length,
	input  logic [hpd_pkg::ENTRY_CODE_W-1:0]   entry_code,
	input  logic [hpd_pkg::BYTE_W-1:0]         data_byte,
	input  logic [hpd_pkg::VALID_BITS_W-1:0]   valid_bits,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [hpd_pkg::ENTRY_SYMBOL_W-1:0] symbol,
	output logic                            status,
	output logic                            last_of_item
);

	hpd_pkg::ctrl_cmd_t cmd;
	hpd_pkg::dp_stat_t  stat;

	// Sequencer: one bit at a time, shift -> scan -> place result (on a hit or at the maximum code length) -> next bit,
	// then flush the held result with last_of_item set.
	hpd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.valid_bits (valid_bits),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Table memory plus valid bits, partial code, scan compare, and a
	// one-deep hold slot so the last result of a byte can be marked.
	hpd_datapath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.entry_index  (entry_index),
		.entry_symbol (entry_symbol),
		.entry_length (entry_length),
		.entry_code   (entry_code),
		.data_byte    (data_byte),
		.valid_bits   (valid_bits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.status       (status),
		.last_of_item (last_of_item)
	);

endmodule
